>>> rtl/core/tcw_pkg.sv
// tcw_pkg: screen geometry, command codes, sweep ranges and the
// controller/datapath interface types of the text console cell writer.
// No dependencies.
package tcw_pkg;

  // screen geometry
  localparam int COLUMNS           = 80;
  localparam int ROWS              = 25;
  localparam int FIRST_CONTENT_ROW = 1;
  localparam int LAST_CONTENT_ROW  = 23;
  localparam int BACKSPACE_FLOOR   = 2;

  localparam int CELLS  = ROWS * COLUMNS;
  localparam int ADDR_W = $clog2(CELLS);

  // field widths
  localparam int MODE_W = 3;
  localparam int CHAR_W = 8;
  localparam int ROW_W  = 5;
  localparam int COL_W  = 7;
  localparam int CELL_W = 16;
  localparam int ATTR_W = 8;

  // register port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam int REG_W  = APB_AW - 2;
  localparam logic [REG_W-1:0] REG_TEXT_COLOR = REG_W'(0);
  localparam logic [ATTR_W-1:0] COLOR_RESET   = 8'd7;

  // command codes
  localparam logic [MODE_W-1:0] MODE_PUT         = MODE_W'(0);
  localparam logic [MODE_W-1:0] MODE_BKSP        = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_CLR_CONTENT = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_CLR_SCREEN  = MODE_W'(3);
  localparam logic [MODE_W-1:0] MODE_READ        = MODE_W'(4);

  // character codes
  localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;
  localparam logic [CHAR_W-1:0] SPACE_CODE   = 8'h20;

  // cursor limits
  localparam logic [ROW_W-1:0] HOME_ROW = ROW_W'(FIRST_CONTENT_ROW);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(LAST_CONTENT_ROW);
  localparam logic [COL_W-1:0] LAST_COL = COL_W'(COLUMNS - 1);
  localparam logic [COL_W-1:0] BS_FLOOR = COL_W'(BACKSPACE_FLOOR);

  // rows that move up on a scroll exist only with two or more content rows
  localparam bit HAS_COPY = LAST_CONTENT_ROW > FIRST_CONTENT_ROW;

  // flat cell address ranges of the sweeps
  localparam logic [ADDR_W-1:0] ROW_STRIDE = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] SCREEN_LO  = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] SCREEN_HI  = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] CONTENT_LO = ADDR_W'(FIRST_CONTENT_ROW * COLUMNS);
  localparam logic [ADDR_W-1:0] CONTENT_HI = ADDR_W'((LAST_CONTENT_ROW + 1) * COLUMNS - 1);
  localparam logic [ADDR_W-1:0] COPY_LO    = ADDR_W'((FIRST_CONTENT_ROW + 1) * COLUMNS);
  localparam logic [ADDR_W-1:0] LASTROW_LO = ADDR_W'(LAST_CONTENT_ROW * COLUMNS);

  typedef enum logic [2:0] {
    SW_INIT,
    SW_SCREEN,
    SW_CONTENT,
    SW_COPY,
    SW_LAST
  } sweep_e;

  // controller to datapath
  typedef struct packed {
    logic   latch;
    logic   put;
    logic   bksp;
    logic   home;
    logic   rd_item;
    logic   sweep_init;
    sweep_e sweep_kind;
    logic   fill;
    logic   copy;
    logic   out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              put_scroll;
    logic              sweep_last;
  } stat_t;

  // flat address of a cell
  function automatic logic [ADDR_W-1:0] cell_addr(logic [ROW_W-1:0] row,
                                                  logic [COL_W-1:0] col);
    cell_addr = ADDR_W'(row) * ROW_STRIDE + ADDR_W'(col);
  endfunction

endpackage

>>> rtl/core/tcw_datapath.sv
// tcw_datapath: cell memory, cursor, sweep address counter, copy pipeline
// and result register of the text console cell writer.
// Depends on tcw_pkg; steered by tcw_ctrl through cmd_t / stat_t.
module tcw_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tcw_pkg::cmd_t                cmd_i,
  output tcw_pkg::stat_t               stat_o,
  input  logic [tcw_pkg::ATTR_W-1:0]   text_color_i,
  input  logic [tcw_pkg::MODE_W-1:0]   mode_i,
  input  logic [tcw_pkg::CHAR_W-1:0]   char_code_i,
  input  logic [tcw_pkg::ROW_W-1:0]    read_row_i,
  input  logic [tcw_pkg::COL_W-1:0]    read_col_i,
  output logic [tcw_pkg::ROW_W-1:0]    cursor_row_o,
  output logic [tcw_pkg::COL_W-1:0]    cursor_col_o,
  output logic [tcw_pkg::CELL_W-1:0]   cell_data_o,
  output logic                         scrolled_o
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [CELLS];

  logic [MODE_W-1:0] mode_q;
  logic [CHAR_W-1:0] char_q;
  logic [ROW_W-1:0]  read_row_q;
  logic [COL_W-1:0]  read_col_q;

  logic [ROW_W-1:0]  cur_row_q;
  logic [COL_W-1:0]  cur_col_q;
  logic              scrolled_q;
  logic [ADDR_W-1:0] addr_q;
  sweep_e            sweep_kind_q;
  logic              cp_v_q;
  logic [ADDR_W-1:0] cp_addr_q;
  logic              rd_ok_q;
  logic [CELL_W-1:0] rdata_q;

  logic [ROW_W-1:0]  out_row_q;
  logic [COL_W-1:0]  out_col_q;
  logic [CELL_W-1:0] out_data_q;
  logic              out_scrolled_q;

  logic              is_nl;
  logic              wrap;
  logic              row_adv;
  logic              put_scroll;
  logic [ROW_W-1:0]  put_row;
  logic [COL_W-1:0]  put_col;
  logic              bksp_ok;
  logic [COL_W-1:0]  bksp_col;
  logic [CELL_W-1:0] blank_cell;
  logic [ADDR_W-1:0] sweep_lo;
  logic [ADDR_W-1:0] sweep_hi;
  logic              rd_in_range;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CELL_W-1:0] wdata;
  logic              re;
  logic [ADDR_W-1:0] raddr;

  // cursor advance for put char
  assign is_nl      = (char_q == NEWLINE_CODE);
  assign wrap       = !is_nl && (cur_col_q == LAST_COL);
  assign row_adv    = is_nl || wrap;
  assign put_scroll = row_adv && (cur_row_q == LAST_ROW);
  assign put_row    = put_scroll ? LAST_ROW : cur_row_q + ROW_W'(row_adv);
  assign put_col    = row_adv ? '0 : cur_col_q + COL_W'(1);

  // backspace
  assign bksp_ok  = (cur_col_q > BS_FLOOR);
  assign bksp_col = cur_col_q - COL_W'(1);

  assign blank_cell  = {text_color_i, SPACE_CODE};
  assign rd_in_range = (int'(read_row_q) < ROWS) && (int'(read_col_q) < COLUMNS);

  // sweep start for a new sweep
  always_comb begin
    unique case (cmd_i.sweep_kind)
      SW_CONTENT: sweep_lo = CONTENT_LO;
      SW_COPY:    sweep_lo = COPY_LO;
      SW_LAST:    sweep_lo = LASTROW_LO;
      default:    sweep_lo = SCREEN_LO;
    endcase
  end

  // sweep end for the running sweep
  always_comb begin
    unique case (sweep_kind_q)
      SW_CONTENT: sweep_hi = CONTENT_HI;
      SW_COPY:    sweep_hi = CONTENT_HI;
      SW_LAST:    sweep_hi = CONTENT_HI;
      default:    sweep_hi = SCREEN_HI;
    endcase
  end

  assign stat_o.mode       = mode_q;
  assign stat_o.put_scroll = put_scroll;
  assign stat_o.sweep_last = (addr_q == sweep_hi);

  // memory write port: copy beat, fill, put char, backspace
  always_comb begin
    we    = 1'b0;
    waddr = addr_q;
    wdata = blank_cell;
    priority if (cp_v_q) begin
      we    = 1'b1;
      waddr = cp_addr_q;
      wdata = rdata_q;
    end else if (cmd_i.fill) begin
      we    = 1'b1;
      wdata = (sweep_kind_q == SW_INIT) ? '0 : blank_cell;
    end else if (cmd_i.put && !is_nl) begin
      we    = 1'b1;
      waddr = cell_addr(cur_row_q, cur_col_q);
      wdata = {text_color_i, char_q};
    end else if (cmd_i.bksp && bksp_ok) begin
      we    = 1'b1;
      waddr = cell_addr(cur_row_q, bksp_col);
    end
  end

  // memory read port: copy source or addressed cell
  assign re    = cmd_i.copy || (cmd_i.rd_item && rd_in_range);
  assign raddr = cmd_i.copy ? addr_q : cell_addr(read_row_q, read_col_q);

  // cell memory
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  // cursor, sweep counter and copy pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_row_q    <= HOME_ROW;
      cur_col_q    <= '0;
      scrolled_q   <= 1'b0;
      addr_q       <= SCREEN_LO;
      sweep_kind_q <= SW_INIT;
      cp_v_q       <= 1'b0;
    end else begin
      if (cmd_i.latch) begin
        scrolled_q <= 1'b0;
      end
      if (cmd_i.put) begin
        cur_row_q  <= put_row;
        cur_col_q  <= put_col;
        scrolled_q <= put_scroll;
      end
      if (cmd_i.bksp && bksp_ok) begin
        cur_col_q <= bksp_col;
      end
      if (cmd_i.home) begin
        cur_row_q <= HOME_ROW;
        cur_col_q <= '0;
      end
      if (cmd_i.sweep_init) begin
        addr_q       <= sweep_lo;
        sweep_kind_q <= cmd_i.sweep_kind;
      end else if (cmd_i.fill || cmd_i.copy) begin
        addr_q <= addr_q + ADDR_W'(1);
      end
      cp_v_q <= cmd_i.copy;
    end
  end

  // item capture, copy destination, read flag and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      mode_q     <= mode_i;
      char_q     <= char_code_i;
      read_row_q <= read_row_i;
      read_col_q <= read_col_i;
    end
    cp_addr_q <= addr_q - ROW_STRIDE;
    if (cmd_i.rd_item) begin
      rd_ok_q <= rd_in_range;
    end
    if (cmd_i.out_load) begin
      out_row_q      <= cur_row_q;
      out_col_q      <= cur_col_q;
      out_data_q     <= ((mode_q == MODE_READ) && rd_ok_q) ? rdata_q : '0;
      out_scrolled_q <= scrolled_q;
    end
  end

  assign cursor_row_o = out_row_q;
  assign cursor_col_o = out_col_q;
  assign cell_data_o  = out_data_q;
  assign scrolled_o   = out_scrolled_q;

endmodule

>>> rtl/core/tcw_ctrl.sv
// tcw_ctrl: command sequencer of the text console cell writer; runs the
// reset clear, item decode, copy and fill sweeps and the result handshake.
// Depends on tcw_pkg; drives tcw_datapath through cmd_t.
module tcw_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  tcw_pkg::stat_t stat_i,
  output tcw_pkg::cmd_t  cmd_o
);
  import tcw_pkg::*;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_EXEC,
    S_COPY,
    S_FLUSH,
    S_FILL,
    S_READ,
    S_RESULT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.sweep_kind = SW_SCREEN;
    unique case (state_q)
      S_INIT: begin
        cmd_o.fill = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_EXEC;
        end
      end
      S_EXEC: begin
        priority if (stat_i.mode == MODE_PUT) begin
          cmd_o.put = 1'b1;
          if (stat_i.put_scroll) begin
            cmd_o.sweep_init = 1'b1;
            cmd_o.sweep_kind = HAS_COPY ? SW_COPY : SW_LAST;
            state_d          = HAS_COPY ? S_COPY : S_FILL;
          end else begin
            state_d = S_RESULT;
          end
        end else if (stat_i.mode == MODE_BKSP) begin
          cmd_o.bksp = 1'b1;
          state_d    = S_RESULT;
        end else if (stat_i.mode == MODE_CLR_CONTENT) begin
          cmd_o.home       = 1'b1;
          cmd_o.sweep_init = 1'b1;
          cmd_o.sweep_kind = SW_CONTENT;
          state_d          = S_FILL;
        end else if (stat_i.mode == MODE_CLR_SCREEN) begin
          cmd_o.home       = 1'b1;
          cmd_o.sweep_init = 1'b1;
          cmd_o.sweep_kind = SW_SCREEN;
          state_d          = S_FILL;
        end else if (stat_i.mode == MODE_READ) begin
          cmd_o.rd_item = 1'b1;
          state_d       = S_READ;
        end else begin
          state_d = S_RESULT;
        end
      end
      // one cell moved up a row per cycle over the content rows below the first
      S_COPY: begin
        cmd_o.copy = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = S_FLUSH;
        end
      end
      // last copy beat writes back, then blank the bottom content row
      S_FLUSH: begin
        cmd_o.sweep_init = 1'b1;
        cmd_o.sweep_kind = SW_LAST;
        state_d          = S_FILL;
      end
      S_FILL: begin
        cmd_o.fill = 1'b1;
        if (stat_i.sweep_last) begin
          state_d = S_RESULT;
        end
      end
      S_READ: begin
        state_d = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/core/text_console_cell_writer.sv
// Text console cell writer: a 25 x 80 store of 16-bit character cells
// (attribute in the high byte, character in the low byte) with a text
// cursor over content rows 1 to 23. Commands: put char (10 is newline),
// backspace (only above column 2), clear content rows, clear screen, read
// one cell. One result beat per command. After reset the block zeroes the
// cell memory, one cell per cycle, before in_ready_o rises; register
// writes are taken meanwhile. Unused command codes leave the cells and
// cursor alone and only return a result beat. The single write port of
// the cell memory sets the pace of the sweeps: a scroll moves 1760 cells
// one per cycle and blanks 80 more, a clear writes one cell per cycle.
// A new command is taken while the previous result waits in the output
// register. text_color sits at byte address 0 of the register port.
// Depends on tcw_pkg, tcw_ctrl and tcw_datapath.
module text_console_cell_writer (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tcw_pkg::APB_AW-1:0]   paddr,
  input  logic [tcw_pkg::APB_DW-1:0]   pwdata,
  output logic [tcw_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [tcw_pkg::MODE_W-1:0]   mode_i,
  input  logic [tcw_pkg::CHAR_W-1:0]   char_code_i,
  input  logic [tcw_pkg::ROW_W-1:0]    read_row_i,
  input  logic [tcw_pkg::COL_W-1:0]    read_col_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tcw_pkg::ROW_W-1:0]    cursor_row_o,
  output logic [tcw_pkg::COL_W-1:0]    cursor_col_o,
  output logic [tcw_pkg::CELL_W-1:0]   cell_data_o,
  output logic                         scrolled_o
);
  import tcw_pkg::*;

  logic [ATTR_W-1:0] text_color_q;
  logic              reg_hit;
  cmd_t              cmd;
  stat_t             stat;

  // register port
  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_AW-1:2] == REG_TEXT_COLOR);
  assign prdata  = reg_hit ? APB_DW'(text_color_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_color_q <= COLOR_RESET;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      text_color_q <= pwdata[ATTR_W-1:0];
    end
  end

  // sequencer
  tcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // cell memory and cursor
  tcw_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .text_color_i (text_color_q),
    .mode_i       (mode_i),
    .char_code_i  (char_code_i),
    .read_row_i   (read_row_i),
    .read_col_i   (read_col_i),
    .cursor_row_o (cursor_row_o),
    .cursor_col_o (cursor_col_o),
    .cell_data_o  (cell_data_o),
    .scrolled_o   (scrolled_o)
  );

endmodule

>>> rtl/core/tcw_checker.sv
// tcw_checker: port-level assertions on the result channel of the text
// console cell writer, bound to the top level.
// Depends on tcw_pkg.
module tcw_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [tcw_pkg::ROW_W-1:0]    cursor_row_o,
  input logic [tcw_pkg::COL_W-1:0]    cursor_col_o,
  input logic [tcw_pkg::CELL_W-1:0]   cell_data_o,
  input logic                         scrolled_o
);
  import tcw_pkg::*;

  // a stalled result beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result beat dropped while stalled");

  // a stalled result beat keeps its payload
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(cursor_row_o) && $stable(cursor_col_o)
      && $stable(cell_data_o) && $stable(scrolled_o))
    else $error("result payload changed while stalled");

  // reported cursor stays inside the content region
  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> cursor_row_o >= HOME_ROW && cursor_row_o <= LAST_ROW
      && cursor_col_o <= LAST_COL)
    else $error("cursor outside content region");

  // a scroll leaves the cursor on the bottom content row and reads nothing
  a_scroll_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && scrolled_o |-> cursor_row_o == LAST_ROW && cell_data_o == '0)
    else $error("scroll result inconsistent");

endmodule

bind text_console_cell_writer tcw_checker u_chk (.*);

>>> tb/testbench.sv
// Self-checking testbench for text_console_cell_writer: a directed table of
// commands, then randomized command sequences checked against a cycle-free
// model of the screen store and cursor. Depends on tcw_pkg and the block.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import tcw_pkg::*;

  // unused command codes and register addresses
  localparam logic [MODE_W-1:0] MODE_RSVD5 = MODE_W'(5);
  localparam logic [MODE_W-1:0] MODE_RSVD6 = MODE_W'(6);
  localparam logic [MODE_W-1:0] MODE_RSVD7 = MODE_W'(7);
  localparam logic [APB_AW-1:0] ADDR_TEXT_COLOR = {REG_TEXT_COLOR, 2'b00};
  localparam logic [APB_AW-1:0] ADDR_SPARE      = APB_AW'(4);

  localparam int IDLE_PCT      = 28;
  localparam int PHASE_ITEMS   = 230;
  localparam int HOLD_AT       = 450;
  localparam int HOLD_CYCLES   = 600;
  localparam int SETTLE_CYCLES = 20;
  localparam int CYCLE_LIMIT   = 12_000_000;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CELL_W-1:0] cell_data;
    logic              scrolled;
  } console_resp_t;

  typedef struct {
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
    bit                typed;
    console_resp_t     resp;
  } console_cmd_t;

  // dut ports
  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [APB_AW-1:0] paddr = '0;
  logic [APB_DW-1:0] pwdata = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic [MODE_W-1:0] mode_i = '0;
  logic [CHAR_W-1:0] char_code_i = '0;
  logic [ROW_W-1:0]  read_row_i = '0;
  logic [COL_W-1:0]  read_col_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [ROW_W-1:0]  cursor_row_o;
  logic [COL_W-1:0]  cursor_col_o;
  logic [CELL_W-1:0] cell_data_o;
  logic              scrolled_o;

  // side info travelling with the offered beat
  logic          offered_typed = 1'b0;
  console_resp_t offered_resp = '0;

  // screen shadow and cursor
  logic [CELL_W-1:0] shadow_cells [ROWS][COLUMNS];
  int                crs_row = FIRST_CONTENT_ROW;
  int                crs_col = 0;
  logic [ATTR_W-1:0] attr_q = COLOR_RESET;

  console_resp_t console_resp_q [$];
  console_cmd_t  dir_tab [$];
  int            err_cnt = 0;
  int            beats_sent = 0;
  int            results_seen = 0;
  int            cycle_cnt = 0;
  logic          calm = 1'b0;
  int            hold_left = 0;
  bit            hold_done = 1'b0;

  text_console_cell_writer dut (.*);

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_cnt);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic put_cell(input int r, input int c, input logic [CHAR_W-1:0] ch);
    if (r < ROWS && c < COLUMNS) shadow_cells[r][c] = {attr_q, ch};
  endtask

  task automatic blank_rows(input int first, input int last);
    int r, c;
    for (r = first; r <= last && r < ROWS; r++)
      for (c = 0; c < COLUMNS; c++) put_cell(r, c, SPACE_CODE);
  endtask

  // next cursor, read data and scroll flag for one command
  task automatic step_console(input logic [MODE_W-1:0] m, input logic [CHAR_W-1:0] ch,
                              input logic [ROW_W-1:0] rr, input logic [COL_W-1:0] rc,
                              output console_resp_t resp);
    int r, c;
    resp = '0;
    case (m)
      MODE_PUT: begin
        if (ch == NEWLINE_CODE) begin
          crs_col = 0;
          crs_row++;
        end else begin
          put_cell(crs_row, crs_col, ch);
          crs_col++;
        end
        if (crs_col >= COLUMNS) begin
          crs_col = 0;
          crs_row++;
        end
        // ran off the content region: move rows up, blank the last one
        if (crs_row > LAST_CONTENT_ROW) begin
          for (r = FIRST_CONTENT_ROW + 1; r <= LAST_CONTENT_ROW && r < ROWS; r++)
            for (c = 0; c < COLUMNS; c++) shadow_cells[r-1][c] = shadow_cells[r][c];
          blank_rows(LAST_CONTENT_ROW, LAST_CONTENT_ROW);
          crs_row = LAST_CONTENT_ROW;
          resp.scrolled = 1'b1;
        end
      end
      MODE_BKSP: begin
        if (crs_col > BACKSPACE_FLOOR) begin
          crs_col--;
          put_cell(crs_row, crs_col, SPACE_CODE);
        end
      end
      MODE_CLR_CONTENT: begin
        blank_rows(FIRST_CONTENT_ROW, LAST_CONTENT_ROW);
        crs_row = FIRST_CONTENT_ROW;
        crs_col = 0;
      end
      MODE_CLR_SCREEN: begin
        blank_rows(0, ROWS - 1);
        crs_row = FIRST_CONTENT_ROW;
        crs_col = 0;
      end
      MODE_READ: begin
        if (rr < ROWS && rc < COLUMNS) resp.cell_data = shadow_cells[rr][rc];
      end
      default: begin
      end
    endcase
    resp.row = ROW_W'(crs_row);
    resp.col = COL_W'(crs_col);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected 'h%0h, actual 'h%0h", $time, name, want, got);
      err_cnt++;
    end
  endtask

  // result beats against the oldest expectation, then predict accepted beats
  always @(posedge clk_i) begin : watch_beats
    console_resp_t got, want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got.row = cursor_row_o;
        got.col = cursor_col_o;
        got.cell_data = cell_data_o;
        got.scrolled = scrolled_o;
        if (console_resp_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual 'h%0h", $time, got);
          err_cnt++;
        end else begin
          want = console_resp_q.pop_front();
          check_field("cursor_row", want.row, got.row);
          check_field("cursor_col", want.col, got.col);
          check_field("cell_data", want.cell_data, got.cell_data);
          check_field("scrolled", want.scrolled, got.scrolled);
        end
        results_seen <= results_seen + 1;
      end
      if (in_valid_i && in_ready_o) begin
        step_console(mode_i, char_code_i, read_row_i, read_col_i, want);
        if (offered_typed) want = offered_resp;
        console_resp_q.push_back(want);
      end
    end
  end

  // receiver: random stalls, one long hold-off
  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready_i <= 1'b0;
    end else if (!hold_done && results_seen == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  function automatic console_cmd_t plain_cmd(input logic [MODE_W-1:0] m,
                                             input int ch,
                                             input int rr,
                                             input int rc);
    console_cmd_t c;
    c.mode = m;
    c.char_code = CHAR_W'(ch);
    c.read_row = ROW_W'(rr);
    c.read_col = COL_W'(rc);
    c.typed = 1'b0;
    c.resp = '0;
    return c;
  endfunction

  function automatic console_cmd_t dir_row(input logic [MODE_W-1:0] m, input int ch,
                                           input int rr, input int rc, input bit typed,
                                           input int er, input int ec, input int ed);
    console_cmd_t c;
    c = plain_cmd(m, ch, rr, rc);
    c.typed = typed;
    c.resp.row = ROW_W'(er);
    c.resp.col = COL_W'(ec);
    c.resp.cell_data = CELL_W'(ed);
    c.resp.scrolled = 1'b0;
    return c;
  endfunction

  function automatic logic [CHAR_W-1:0] text_byte();
    return CHAR_W'(($urandom_range(3) == 0) ? $urandom_range(255) : $urandom_range(32, 126));
  endfunction

  // one input beat, with a random gap ahead of it
  task automatic offer_command(input console_cmd_t c);
    int gap;
    gap = 0;
    if (!calm) while ($urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    mode_i <= c.mode;
    char_code_i <= c.char_code;
    read_row_i <= c.read_row;
    read_col_i <= c.read_col;
    offered_typed <= c.typed;
    offered_resp <= c.resp;
    do @(posedge clk_i); while (!in_ready_o);
    beats_sent++;
  endtask

  // stop offering until every result beat is back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (results_seen != beats_sent) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [APB_AW-1:0] addr, input logic [APB_DW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == ADDR_TEXT_COLOR) attr_q = data[ATTR_W-1:0];
  endtask

  // random command sequences: text runs, line feeds, backspaces, reads, clears
  task automatic run_random_phase(input int n_items);
    int done, len, pick, k;
    done = 0;
    while (done < n_items) begin
      pick = $urandom_range(99);
      if (pick < 38) begin
        len = $urandom_range(1, 100);
        for (k = 0; k < len; k++)
          offer_command(plain_cmd(MODE_PUT, text_byte(), $urandom_range(31),
                                  $urandom_range(127)));
        done += len;
      end else if (pick < 53) begin
        len = $urandom_range(1, 24);
        for (k = 0; k < len; k++)
          offer_command(plain_cmd(MODE_PUT,
                                  ($urandom_range(99) < 85) ? NEWLINE_CODE : text_byte(),
                                  $urandom_range(31), $urandom_range(127)));
        done += len;
      end else if (pick < 66) begin
        len = $urandom_range(0, 8);
        for (k = 0; k < len; k++)
          offer_command(plain_cmd(MODE_PUT, text_byte(), $urandom_range(31),
                                  $urandom_range(127)));
        done += len;
        len = $urandom_range(1, 12);
        for (k = 0; k < len; k++)
          offer_command(plain_cmd(MODE_BKSP, $urandom_range(255), $urandom_range(31),
                                  $urandom_range(127)));
        done += len;
      end else if (pick < 84) begin
        len = $urandom_range(1, 6);
        for (k = 0; k < len; k++) begin
          if ($urandom_range(99) < 20)
            offer_command(plain_cmd(MODE_READ, $urandom_range(255), $urandom_range(31),
                                    $urandom_range(127)));
          else
            offer_command(plain_cmd(MODE_READ, $urandom_range(255), $urandom_range(ROWS - 1),
                                    $urandom_range(COLUMNS - 1)));
        end
        done += len;
      end else if (pick < 88) begin
        offer_command(plain_cmd(MODE_CLR_CONTENT, $urandom_range(255), $urandom_range(31),
                                $urandom_range(127)));
        done++;
      end else if (pick < 90) begin
        offer_command(plain_cmd(MODE_CLR_SCREEN, $urandom_range(255), $urandom_range(31),
                                $urandom_range(127)));
        done++;
      end else begin
        // noise: unused codes, ignored by the block
        len = $urandom_range(1, 4);
        for (k = 0; k < len; k++)
          offer_command(plain_cmd(MODE_W'($urandom_range(MODE_RSVD5, MODE_RSVD7)),
                                  $urandom_range(255), $urandom_range(31),
                                  $urandom_range(127)));
        done += len;
      end
    end
  endtask

  // main sequence
  initial begin : main_flow
    int r, c, ph;
    for (r = 0; r < ROWS; r++)
      for (c = 0; c < COLUMNS; c++) shadow_cells[r][c] = '0;

    // directed table: typed where the answer is plain
    dir_tab.push_back(dir_row(MODE_READ,        8'h00,  0,   0, 1, 1, 0, 16'h0000));
    dir_tab.push_back(dir_row(MODE_READ,        8'hff, 31, 127, 1, 1, 0, 16'h0000));
    dir_tab.push_back(dir_row(MODE_READ,        8'h00, 24,  80, 1, 1, 0, 16'h0000));
    dir_tab.push_back(dir_row(MODE_READ,        8'h00, 25,   0, 1, 1, 0, 16'h0000));
    dir_tab.push_back(dir_row(MODE_BKSP,        8'h00,  0,   0, 1, 1, 0, 16'h0000));
    dir_tab.push_back(dir_row(MODE_PUT,         8'h41,  0,   0, 1, 1, 1, 16'h0000));
    dir_tab.push_back(dir_row(MODE_PUT,         8'hff, 31, 127, 1, 1, 2, 16'h0000));
    dir_tab.push_back(dir_row(MODE_PUT,         8'h00,  0,   0, 1, 1, 3, 16'h0000));
    dir_tab.push_back(dir_row(MODE_BKSP,        8'h00,  0,   0, 1, 1, 2, 16'h0000));
    dir_tab.push_back(dir_row(MODE_BKSP,        8'h00,  0,   0, 1, 1, 2, 16'h0000));
    dir_tab.push_back(dir_row(MODE_READ,        8'h00,  1,   0, 1, 1, 2, 16'h0741));
    dir_tab.push_back(dir_row(MODE_READ,        8'h00,  1,   1, 1, 1, 2, 16'h07ff));
    dir_tab.push_back(dir_row(MODE_READ,        8'h00,  1,   2, 1, 1, 2, 16'h0720));
    dir_tab.push_back(dir_row(MODE_PUT,  NEWLINE_CODE,  0,   0, 1, 2, 0, 16'h0000));
    dir_tab.push_back(dir_row(MODE_RSVD5,       8'hff, 31, 127, 1, 2, 0, 16'h0000));
    dir_tab.push_back(dir_row(MODE_RSVD6,       8'h00,  1,   0, 1, 2, 0, 16'h0000));
    dir_tab.push_back(dir_row(MODE_RSVD7,       8'hff, 31, 127, 1, 2, 0, 16'h0000));
    dir_tab.push_back(dir_row(MODE_CLR_CONTENT, 8'h00,  0,   0, 1, 1, 0, 16'h0000));
    dir_tab.push_back(dir_row(MODE_READ,        8'h00,  0,   5, 1, 1, 0, 16'h0000));
    dir_tab.push_back(dir_row(MODE_READ,        8'h00, 23,  79, 1, 1, 0, 16'h0720));
    dir_tab.push_back(dir_row(MODE_READ,        8'h00, 24,  79, 1, 1, 0, 16'h0000));
    dir_tab.push_back(dir_row(MODE_CLR_SCREEN,  8'h00,  0,   0, 1, 1, 0, 16'h0000));
    dir_tab.push_back(dir_row(MODE_READ,        8'h00,  0,   0, 1, 1, 0, 16'h0720));
    dir_tab.push_back(dir_row(MODE_READ,        8'h00, 24,  79, 1, 1, 0, 16'h0720));
    dir_tab.push_back(dir_row(MODE_PUT,         8'h5a,  0,   0, 0, 0, 0, 16'h0000));

    // reset
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // write beyond the register list, must leave the color at its reset value
    reg_write(ADDR_SPARE, 32'hffff_ffff);

    foreach (dir_tab[i]) offer_command(dir_tab[i]);

    // random phases, color changed between them with the block idle
    for (ph = 0; ph < 4; ph++) begin
      wait_idle();
      case (ph)
        0: reg_write(ADDR_TEXT_COLOR, 32'h0000_0000);
        1: reg_write(ADDR_TEXT_COLOR, 32'hffff_ffff);
        default: reg_write(ADDR_TEXT_COLOR, $urandom_range(1, 254));
      endcase
      calm <= (ph == 1);
      run_random_phase(PHASE_ITEMS);
    end
    calm <= 1'b0;

    // drain
    wait_idle();
    if (console_resp_q.size() != 0) begin
      $display("%0t: result beats missing, expected %0d more, actual 0", $time,
               console_resp_q.size());
      err_cnt++;
    end
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_datapath.sv
rtl/core/tcw_ctrl.sv
rtl/core/text_console_cell_writer.sv
rtl/core/tcw_checker.sv
tb/testbench.sv
